### hdl/gb3_pkg.sv
package gb3_pkg;

  localparam int MaxCols = 1024;
  localparam int ColW = $clog2(MaxCols);
  localparam int PixW = 24;

  localparam logic [0:0] CfgRows = 1'b0;
  localparam logic [0:0] CfgCols = 1'b1;

  typedef logic [PixW-1:0] pix_t;
  typedef logic [ColW-1:0] col_t;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       last_of_step;
    logic       frame_end;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [15:0] data;
  } cfg_item_t;

  // Weighted sum of one 8-bit channel over a 3x3 window, shifted.
  function automatic logic [7:0] blur_chan(input logic [7:0] a0, a1, a2,
                                           input logic [7:0] b0, b1, b2,
                                           input logic [7:0] c0, c1, c2);
    logic [11:0] s;
    logic [7:0]  v;
    s = {4'd0, a0} + {3'd0, a1, 1'b0} + {4'd0, a2}
      + {3'd0, b0, 1'b0} + {2'd0, b1, 2'b0} + {3'd0, b2, 1'b0}
      + {4'd0, c0} + {3'd0, c1, 1'b0} + {4'd0, c2};
    v = s[11:4];
    return v;
  endfunction

  // Smooth a pixel: columns l, m, r, rows up, ce, dn.
  function automatic pix_t blur_pix(input pix_t lu, mu, ru, lc, mc, rc, ld, md, rd);
    pix_t o;
    for (int k = 0; k < 3; k++) begin
      o[8*k +: 8] = blur_chan(lu[8*k +: 8], mu[8*k +: 8], ru[8*k +: 8],
                              lc[8*k +: 8], mc[8*k +: 8], rc[8*k +: 8],
                              ld[8*k +: 8], md[8*k +: 8], rd[8*k +: 8]);
    end
    return o;
  endfunction

endpackage

### hdl/gb3_stream_if.sv
interface gb3_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/gaussian_blur_3x3_rgb.sv
// Channel | Port prefix | Payload                                  | Direction
// input   | in_         | red_in, green_in, blue_in                | sink
// result  | out_        | red_out, green_out, blue_out, flags      | source
// config  | cfg_        | index (0 rows, 1 cols), data             | sink
//
// At most one pixel is accepted per cycle, and only while no results are pending or the
// last one of the step is being taken; it causes zero to four results, and the input is
// held while they drain. The two row stores are read ahead, at the column of the next
// pixel; a read of a column that is still being written is served by forwarding from the
// pending write. Reset (rst_n low, synchronous) clears position and window, and sets
// both frame sizes to 1. Row stores are not cleared.
module gaussian_blur_3x3_rgb (
  input logic clk,
  input logic rst_n,
  gb3_stream_if.sink   in_ch,
  gb3_stream_if.source out_ch,
  gb3_stream_if.sink   cfg_ch
);
  import gb3_pkg::*;

  localparam int ColCntW = ColW + 1;

  logic [15:0]      rows_r;
  logic [10:0]      cols_r;
  logic [15:0]      row_r;
  col_t             col_r;
  pix_t             w1_r [3];
  pix_t             w2_r [3];
  // results of the current step
  pix_t             res_r [4];
  logic [2:0]       nres_r;
  logic [2:0]       idx_r;
  logic             fend_r;
  logic             busy_r;

  logic             in_fire;
  logic [15:0]      rows_e;
  logic [ColCntW-1:0] cols_e;
  logic             row_end, last_row;
  pix_t             rd_old, rd_new, old_q, new_q;
  pix_t             cur [3];
  pix_t             left [3];
  pix_t             eleft [3];
  pix_t             cand [4];
  logic [3:0]       sel;
  pix_t             res_nxt [4];
  logic [2:0]       n_nxt;
  col_t             col_nxt, raddr;
  logic [15:0]      row_nxt;
  logic [1:0]       up1, up2;
  logic             fwd_r;
  pix_t             fwd_old_r, fwd_new_r;
  col_t             fwd_col_r;

  assign cfg_ch.ready = 1'b1;

  // Effective frame sizes.
  always_comb begin
    rows_e = (rows_r == 16'd0) ? 16'd1 : rows_r;
    if (cols_r == 11'd0) begin
      cols_e = ColCntW'(1);
    end else if ({1'b0, cols_r} > 12'(MaxCols)) begin
      cols_e = ColCntW'(MaxCols);
    end else begin
      cols_e = ColCntW'(cols_r);
    end
  end

  assign in_ch.ready = !busy_r || (out_ch.ready && idx_r + 3'd1 >= nres_r);
  assign in_fire = in_ch.valid && in_ch.ready;

  // Store reads are issued for the column of the next pixel.
  assign raddr = in_fire ? col_nxt : col_r;

  gb3_ram #(.Width(PixW), .Depth(MaxCols)) u_old (
    .clk(clk), .we(in_fire), .waddr(col_r), .wdata(new_q),
    .re(1'b1), .raddr(raddr), .rdata(rd_old)
  );
  gb3_ram #(.Width(PixW), .Depth(MaxCols)) u_new (
    .clk(clk), .we(in_fire), .waddr(col_r), .wdata(in_ch.data),
    .re(1'b1), .raddr(raddr), .rdata(rd_new)
  );

  // Forward a write that lands on the column just read.
  assign old_q = (fwd_r && fwd_col_r == col_r) ? fwd_old_r : rd_old;
  assign new_q = (fwd_r && fwd_col_r == col_r) ? fwd_new_r : rd_new;

  always_comb begin
    cur[0] = old_q;
    cur[1] = new_q;
    cur[2] = in_ch.data;
    row_end  = ColCntW'(col_r) >= cols_e - ColCntW'(1);
    last_row = row_r >= rows_e - 16'd1;
    for (int i = 0; i < 3; i++) begin
      left[i]  = (col_r == col_t'(1)) ? w1_r[i] : w2_r[i];
      eleft[i] = (col_r == '0) ? cur[i] : w1_r[i];
    end
    up1 = (row_r == 16'd1) ? 2'd1 : 2'd0;
    up2 = (row_r == 16'd0) ? 2'd2 : 2'd1;
    cand[0] = blur_pix(left[up1], w1_r[up1], cur[up1], left[1], w1_r[1], cur[1],
                       left[2], w1_r[2], cur[2]);
    cand[1] = blur_pix(eleft[up1], cur[up1], cur[up1], eleft[1], cur[1], cur[1],
                       eleft[2], cur[2], cur[2]);
    cand[2] = blur_pix(left[up2], w1_r[up2], cur[up2], left[2], w1_r[2], cur[2],
                       left[2], w1_r[2], cur[2]);
    cand[3] = blur_pix(eleft[up2], cur[up2], cur[up2], eleft[2], cur[2], cur[2],
                       eleft[2], cur[2], cur[2]);
    sel[0] = (row_r != 16'd0) && (col_r != '0);
    sel[1] = (row_r != 16'd0) && row_end;
    sel[2] = last_row && (col_r != '0);
    sel[3] = last_row && row_end;
    // Pack the selected results in order.
    n_nxt = '0;
    for (int i = 0; i < 4; i++) begin
      res_nxt[i] = cand[i];
    end
    for (int i = 0; i < 4; i++) begin
      if (sel[i]) begin
        res_nxt[n_nxt[1:0]] = cand[i];
        n_nxt = n_nxt + 3'd1;
      end
    end
    if (row_end) begin
      col_nxt = '0;
      row_nxt = last_row ? 16'd0 : row_r + 16'd1;
    end else begin
      col_nxt = col_r + col_t'(1);
      row_nxt = row_r;
    end
  end

  assign out_ch.valid = busy_r && (idx_r < nres_r);
  always_comb begin
    out_ch.data.red_out      = res_r[idx_r[1:0]][23:16];
    out_ch.data.green_out    = res_r[idx_r[1:0]][15:8];
    out_ch.data.blue_out     = res_r[idx_r[1:0]][7:0];
    out_ch.data.last_of_step = (idx_r + 3'd1 == nres_r);
    out_ch.data.frame_end    = fend_r && (idx_r + 3'd1 == nres_r);
  end

  // Control, window and result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= 16'd1;
      cols_r <= 11'd1;
      row_r  <= '0;
      col_r  <= '0;
      busy_r <= 1'b0;
      idx_r  <= '0;
      nres_r <= '0;
      fend_r <= 1'b0;
      fwd_r  <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        w1_r[i] <= '0;
        w2_r[i] <= '0;
      end
    end else begin
      if (cfg_ch.valid) begin
        if (cfg_ch.data.index == {1'b0, CfgRows}) begin
          rows_r <= cfg_ch.data.data;
        end else if (cfg_ch.data.index == {1'b0, CfgCols}) begin
          cols_r <= cfg_ch.data.data[10:0];
        end
      end
      fwd_r <= in_fire;
      if (in_fire) begin
        fwd_col_r <= col_r;
        fwd_old_r <= new_q;
        fwd_new_r <= in_ch.data;
        for (int i = 0; i < 3; i++) begin
          w2_r[i] <= w1_r[i];
          w1_r[i] <= cur[i];
          res_r[i] <= res_nxt[i];
        end
        res_r[3] <= res_nxt[3];
        nres_r <= n_nxt;
        idx_r  <= '0;
        busy_r <= (n_nxt != 3'd0);
        fend_r <= sel[3];
        col_r  <= col_nxt;
        row_r  <= row_nxt;
      end else if (out_ch.valid && out_ch.ready) begin
        // A result transfer without a new pixel moves to the next result.
        idx_r <= idx_r + 3'd1;
        if (idx_r + 3'd1 >= nres_r) begin
          busy_r <= 1'b0;
        end
      end
    end
  end
endmodule

### hdl/gb3_ram.sv
module gb3_ram #(
  parameter int Width = 24,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

### sim/gaussian_blur_3x3_rgb_tb.sv
module gaussian_blur_3x3_rgb_tb;
  import gb3_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  gb3_stream_if #(.payload_t(in_item_t))  in_ch ();
  gb3_stream_if #(.payload_t(out_item_t)) out_ch ();
  gb3_stream_if #(.payload_t(cfg_item_t)) cfg_ch ();

  gaussian_blur_3x3_rgb i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predicts the smoothed pixels from accepted inputs and checks each result transfer.
  class blur_scoreboard;
    logic [23:0] older_row [MaxCols];
    logic [23:0] newer_row [MaxCols];
    logic [23:0] win [6];
    int unsigned row_pos;
    int unsigned col_pos;
    int unsigned rows_cfg;
    int unsigned cols_cfg;
    out_item_t pending[$];
    int mismatches;

    function new();
      foreach (older_row[i]) older_row[i] = '0;
      foreach (newer_row[i]) newer_row[i] = '0;
      foreach (win[i]) win[i] = '0;
      row_pos = 0;
      col_pos = 0;
      rows_cfg = 1;
      cols_cfg = 1;
      mismatches = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] val);
      if (idx == 2'(CfgRows)) rows_cfg = val;
      else if (idx == 2'(CfgCols)) cols_cfg = val & 16'h7FF;
    endfunction

    // One smoothed pixel from three columns, each holding rows r-2, r-1, r.
    function out_item_t smooth(logic [23:0] lf[3], logic [23:0] md[3], logic [23:0] rt[3],
                               int up, int ce, int dn);
      out_item_t o;
      int unsigned s;
      int unsigned v;
      logic [7:0] ch [3];
      for (int k = 0; k < 3; k++) begin
        s = lf[up][8*k +: 8] + 2*md[up][8*k +: 8] + rt[up][8*k +: 8]
          + 2*lf[ce][8*k +: 8] + 4*md[ce][8*k +: 8] + 2*rt[ce][8*k +: 8]
          + lf[dn][8*k +: 8] + 2*md[dn][8*k +: 8] + rt[dn][8*k +: 8];
        v = s >> 4;
        if (v > 255) v = 255;
        ch[k] = v[7:0];
      end
      o = '0;
      o.blue_out = ch[0];
      o.green_out = ch[1];
      o.red_out = ch[2];
      return o;
    endfunction

    function void note_pixel(in_item_t px);
      int unsigned rows;
      int unsigned cols;
      int unsigned r;
      int unsigned c;
      logic [23:0] cur[3];
      logic [23:0] w1[3];
      logic [23:0] w2[3];
      logic [23:0] lft[3];
      logic [23:0] elft[3];
      bit row_end;
      bit last_row;
      int up;
      out_item_t res[$];
      out_item_t o;
      rows = (rows_cfg == 0) ? 1 : rows_cfg;
      cols = (cols_cfg == 0) ? 1 : cols_cfg;
      if (cols > MaxCols) cols = MaxCols;
      r = row_pos;
      c = (col_pos >= MaxCols) ? MaxCols - 1 : col_pos;
      cur[0] = older_row[c];
      cur[1] = newer_row[c];
      cur[2] = {px.red_in, px.green_in, px.blue_in};
      for (int i = 0; i < 3; i++) begin
        w1[i] = win[i];
        w2[i] = win[3+i];
      end
      row_end = c >= cols - 1;
      last_row = r >= rows - 1;
      for (int i = 0; i < 3; i++) begin
        lft[i] = (c == 1) ? w1[i] : w2[i];
        elft[i] = (c == 0) ? cur[i] : w1[i];
      end
      if (r >= 1) begin
        up = (r == 1) ? 1 : 0;
        if (c >= 1) res.push_back(smooth(lft, w1, cur, up, 1, 2));
        if (row_end) res.push_back(smooth(elft, cur, cur, up, 1, 2));
      end
      if (last_row) begin
        up = (r == 0) ? 2 : 1;
        if (c >= 1) res.push_back(smooth(lft, w1, cur, up, 2, 2));
        if (row_end) begin
          o = smooth(elft, cur, cur, up, 2, 2);
          o.frame_end = 1'b1;
          res.push_back(o);
        end
      end
      if (res.size() > 0) res[res.size()-1].last_of_step = 1'b1;
      foreach (res[i]) pending.push_back(res[i]);
      older_row[c] = cur[1];
      newer_row[c] = cur[2];
      for (int i = 0; i < 3; i++) begin
        win[3+i] = w1[i];
        win[i] = cur[i];
      end
      if (row_end) begin
        col_pos = 0;
        row_pos = last_row ? 0 : ((r + 1) & 16'hFFFF);
      end else begin
        col_pos = c + 1;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_item;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %h", got);
        return;
      end
      exp_item = pending.pop_front();
      if (got !== exp_item) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch: expected r%h g%h b%h l%b f%b, got r%h g%h b%h l%b f%b",
                   exp_item.red_out, exp_item.green_out, exp_item.blue_out,
                   exp_item.last_of_step, exp_item.frame_end,
                   got.red_out, got.green_out, got.blue_out,
                   got.last_of_step, got.frame_end);
      end
    endfunction
  endclass

  blur_scoreboard sb = new();

  bit stall_hold = 1'b0;
  int idle_cycles = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  // Result side: random stalls, a long hold-off on request, and checking.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
    if (!rst_n || stall_hold) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 1) == 0);
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_item_t item;
    item.index = idx;
    item.data = val;
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= item;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  // Offers one pixel and holds it until the transfer; a gap may follow.
  task automatic send_pixel(in_item_t px, bit gaps);
    in_ch.valid <= 1'b1;
    in_ch.data <= px;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_pixel(px);
    if (gaps && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  function automatic in_item_t rand_pixel();
    in_item_t px;
    case ($urandom_range(0, 5))
      0: px = '0;
      1: px = '1;
      default: px = 24'($urandom);
    endcase
    return px;
  endfunction

  task automatic send_frame(int rows, int cols, bit gaps);
    for (int i = 0; i < rows * cols; i++) send_pixel(rand_pixel(), gaps);
    in_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_size(int rows, int cols);
    write_reg(2'(CfgRows), 16'(rows));
    write_reg(2'(CfgCols), 16'(cols));
  endtask

  initial begin
    int rows;
    int cols;
    int sent;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset size, one row, one column, extremes of pixel values.
    send_pixel('1, 0);
    send_pixel('0, 0);
    in_ch.valid <= 1'b0;
    drain();
    set_size(1, 4);
    send_frame(1, 4, 0);
    drain();
    set_size(4, 1);
    send_frame(4, 1, 0);
    drain();
    set_size(2, 3);
    send_frame(2, 3, 0);
    drain();
    // Zero sizes behave as one.
    set_size(0, 0);
    send_pixel(24'hFF00FF, 0);
    in_ch.valid <= 1'b0;
    drain();

    // Long receiver hold-off while the sender keeps offering.
    set_size(3, 5);
    fork
      begin
        stall_hold = 1'b1;
        repeat (60) @(posedge clk);
        stall_hold = 1'b0;
      end
      send_frame(3, 5, 0);
    join
    drain();

    // Most rows: two rows sent, then the frame is cut short to end at the third.
    set_size(16'hFFFF, 2);
    send_frame(2, 2, 1);
    drain();
    set_size(2, 2);
    send_frame(1, 2, 1);
    drain();
    // Columns beyond the store depth saturate; the row is ended by a smaller size.
    set_size(1, 2047);
    send_frame(1, 3, 0);
    drain();
    set_size(1, 1);
    send_pixel('0, 0);
    in_ch.valid <= 1'b0;
    drain();

    // Random frames of small sizes in bursts with gaps.
    sent = 0;
    while (sent < 240) begin
      rows = $urandom_range(1, 6);
      cols = $urandom_range(1, 8);
      set_size(rows, cols);
      send_frame(rows, cols, 1);
      sent += rows * cols;
      drain();
    end
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
